>>> rtl/core/spi_adc_sequencer_device_core_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the spi adc sequencer device core
// ----------------------------------------------------------------------------
`ifndef SPI_ADC_SEQUENCER_DEVICE_CORE_MACROS_SVH
`define SPI_ADC_SEQUENCER_DEVICE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ADC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ADC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/spiadc_seq_pkg.sv
// ----------------------------------------------------------------------------
// spiadc_seq_pkg
// types and constants of the spi adc sequencer device core
// ----------------------------------------------------------------------------
package spiadc_seq_pkg;

  localparam int CHANNEL_COUNT = 8;
  localparam int SAMPLE_BITS   = 12;

  localparam logic [3:0]  ADDR_NOP      = 4'h0;
  localparam logic [3:0]  ADDR_SEQ      = 4'h2;
  localparam logic [3:0]  ADDR_READBACK = 4'h7;
  localparam logic [3:0]  ADDR_RESET    = 4'hF;
  localparam logic [10:0] RESET_KEY     = 11'h5AC;
  localparam int          RB_ENABLE_BIT = 6;
  localparam int          REPEAT_BIT    = 9;

  typedef struct packed {
    logic [15:0] mosi_frame;
    logic [11:0] sample_ch0;
    logic [11:0] sample_ch1;
    logic [11:0] sample_ch2;
    logic [11:0] sample_ch3;
    logic [11:0] sample_ch4;
    logic [11:0] sample_ch5;
    logic [11:0] sample_ch6;
    logic [11:0] sample_ch7;
  } host_item_t;

  typedef struct packed {
    logic [15:0] miso_frame;
    logic        result_valid;
    logic [2:0]  result_channel;
    logic        readback_valid;
  } dev_item_t;

endpackage

>>> rtl/core/spi_adc_sequencer_device_core.sv
// ----------------------------------------------------------------------------
// spi_adc_sequencer_device_core
// device side of a 16-bit spi adc control interface with a channel sequencer
// ----------------------------------------------------------------------------
// usage
//   host channel (host_valid/host_ready/host_item): one item per spi frame,
//   the host frame plus the current sample of every channel
//   device channel (dev_valid/dev_ready/dev_item): one item per accepted
//   frame, a conversion, readback data or an idle zero frame
//   output: the device item appears in the cycle after its frame is taken
//   throughput: one frame per cycle while not stalled; the only storage
//   between the channels is the output register, and host_ready is high
//   whenever it is empty or being drained in the same cycle
//   stall: while dev_valid is high and dev_ready low the output holds and
//   host_ready is low, so no frame is lost
//   reset: rst clears the register file, sequencer and readback state and
//   empties the output register; a control write of the reset key to the
//   reset address clears the same device state
// ----------------------------------------------------------------------------
`include "spi_adc_sequencer_device_core_macros.svh"

module spi_adc_sequencer_device_core
  import spiadc_seq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       host_valid,
  output logic       host_ready,
  input  host_item_t host_item,
  output logic       dev_valid,
  input  logic       dev_ready,
  output dev_item_t  dev_item
);

  localparam logic [7:0]  CH_MASK     = 8'((1 << CHANNEL_COUNT) - 1);
  localparam logic [11:0] SAMPLE_MASK = 12'((1 << SAMPLE_BITS) - 1);

  // lowest set bit, 8 when none
  function automatic logic [3:0] lowest_set(input logic [7:0] m);
    logic [3:0] res;
    res = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) res = 4'(i);
    end
    return res;
  endfunction

  // device state
  logic [10:0] regfile [16];
  logic [7:0]  seq_mask;
  logic        seq_repeat;
  logic        seq_active;
  logic        seq_warmup;
  logic [2:0]  seq_position;
  logic        rb_pending;
  logic [3:0]  rb_addr;

  logic [7:0]  seq_mask_next;
  logic        seq_repeat_next;
  logic        seq_active_next;
  logic        seq_warmup_next;
  logic [2:0]  seq_position_next;
  logic        rb_pending_next;
  logic [3:0]  rb_addr_next;
  dev_item_t   dev_item_next;

  logic        accept;
  logic [11:0] samples [8];

  // frame decode
  logic        is_ctrl;
  logic [3:0]  frame_addr;
  logic [10:0] frame_data;
  logic        key_reset;
  logic        rf_write;

  // sequencer pick
  logic [7:0]  above_pos;
  logic [3:0]  pick_above;
  logic [3:0]  pick_any;
  logic [3:0]  pick;
  logic [2:0]  chan;
  logic [3:0]  chan_plus;
  logic [7:0]  above_chan;
  logic        more_after;

  assign host_ready = !dev_valid || dev_ready;
  assign accept     = host_valid && host_ready;

  assign samples[0] = host_item.sample_ch0;
  assign samples[1] = host_item.sample_ch1;
  assign samples[2] = host_item.sample_ch2;
  assign samples[3] = host_item.sample_ch3;
  assign samples[4] = host_item.sample_ch4;
  assign samples[5] = host_item.sample_ch5;
  assign samples[6] = host_item.sample_ch6;
  assign samples[7] = host_item.sample_ch7;

  assign is_ctrl    = !host_item.mosi_frame[15];
  assign frame_addr = host_item.mosi_frame[14:11];
  assign frame_data = host_item.mosi_frame[10:0];
  assign key_reset  = is_ctrl && (frame_addr == ADDR_RESET) && (frame_data == RESET_KEY);
  assign rf_write   = is_ctrl && (frame_addr != ADDR_RESET) && (frame_addr != ADDR_NOP);

  // next enabled channel at or above the current position, wrapping to the lowest
  assign above_pos  = seq_mask & (8'hFF << seq_position);
  assign pick_above = lowest_set(above_pos);
  assign pick_any   = lowest_set(seq_mask);
  assign pick       = pick_above[3] ? pick_any : pick_above;
  assign chan       = pick[2:0];
  assign chan_plus  = {1'b0, chan} + 4'd1;
  assign above_chan = seq_mask & (8'hFF << chan_plus);
  assign more_after = |above_chan;

  always_comb begin
    seq_mask_next     = seq_mask;
    seq_repeat_next   = seq_repeat;
    seq_active_next   = seq_active;
    seq_warmup_next   = seq_warmup;
    seq_position_next = seq_position;
    rb_pending_next   = rb_pending;
    rb_addr_next      = rb_addr;
    dev_item_next     = '0;

    // device frame from the state as it stood before this frame
    if (rb_pending) begin
      dev_item_next.miso_frame     = {5'b0, regfile[rb_addr]};
      dev_item_next.readback_valid = 1'b1;
      rb_pending_next              = 1'b0;
    end else if (seq_active && seq_warmup) begin
      seq_warmup_next = 1'b0;
    end else if (seq_active) begin
      if (pick[3]) begin
        seq_active_next = 1'b0;
      end else begin
        dev_item_next.miso_frame     = {1'b0, chan, samples[chan] & SAMPLE_MASK};
        dev_item_next.result_valid   = 1'b1;
        dev_item_next.result_channel = chan;
        if (more_after) begin
          seq_position_next = chan_plus[2:0];
        end else if (seq_repeat) begin
          seq_position_next = '0;
        end else begin
          seq_active_next   = 1'b0;
          seq_position_next = '0;
        end
      end
    end

    // host frame decode
    if (key_reset) begin
      seq_mask_next     = '0;
      seq_repeat_next   = 1'b0;
      seq_active_next   = 1'b0;
      seq_warmup_next   = 1'b0;
      seq_position_next = '0;
      rb_pending_next   = 1'b0;
      rb_addr_next      = '0;
    end else if (rf_write) begin
      if (frame_addr == ADDR_SEQ) begin
        seq_mask_next     = frame_data[7:0] & CH_MASK;
        seq_repeat_next   = frame_data[REPEAT_BIT];
        seq_position_next = '0;
        seq_active_next   = |(frame_data[7:0] & CH_MASK);
        seq_warmup_next   = |(frame_data[7:0] & CH_MASK);
      end else if (frame_addr == ADDR_READBACK && frame_data[RB_ENABLE_BIT]) begin
        rb_pending_next = 1'b1;
        rb_addr_next    = frame_data[5:2];
      end
    end
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_mask     <= '0;
      seq_repeat   <= 1'b0;
      seq_active   <= 1'b0;
      seq_warmup   <= 1'b0;
      seq_position <= '0;
      rb_pending   <= 1'b0;
      rb_addr      <= '0;
      dev_valid    <= 1'b0;
    end else begin
      if (accept) begin
        seq_mask     <= seq_mask_next;
        seq_repeat   <= seq_repeat_next;
        seq_active   <= seq_active_next;
        seq_warmup   <= seq_warmup_next;
        seq_position <= seq_position_next;
        rb_pending   <= rb_pending_next;
        rb_addr      <= rb_addr_next;
        dev_valid    <= 1'b1;
      end else if (dev_ready) begin
        dev_valid <= 1'b0;
      end
    end
  end

  // output payload, loaded only when a frame is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      dev_item <= dev_item_next;
    end
  end

  // register file, cleared by reset or by the reset key
  always_ff @(posedge clk) begin
    if (rst || (accept && key_reset)) begin
      for (int i = 0; i < 16; i++) begin
        regfile[i] <= '0;
      end
    end else if (accept && rf_write) begin
      regfile[frame_addr] <= frame_data;
    end
  end

  // checks
  `ADC_ASSERT_NOW(a_kind_excl, dev_valid,
                  !(dev_item.result_valid && dev_item.readback_valid),
                  "conversion and readback in one item")
  `ADC_ASSERT_NOW(a_rb_low_bits, dev_valid && dev_item.readback_valid,
                  dev_item.miso_frame[15:11] == 5'b0, "readback data outside low bits")
  `ADC_ASSERT_NOW(a_warmup_active, seq_warmup, seq_active,
                  "warm-up without an active sequence")
  `ADC_ASSERT_NOW(a_active_mask, seq_active, seq_mask != 8'b0,
                  "sequence active with empty mask")
  `ADC_ASSERT_NEXT(a_rb_served, accept && rb_pending,
                   dev_valid && dev_item.readback_valid, "pending readback not served")

endmodule
